@@ sv/tfpd_pkg.sv @@
// shared types, constants and the command decode function of the teleop frame parser
// no dependencies
`timescale 1ns / 1ps

package tfpd_pkg;

    localparam int unsigned ByteW        = 8;
    localparam int unsigned LimitW       = 4;
    localparam int unsigned CountW       = 5;
    localparam int unsigned PayloadDepth = 4;
    localparam int unsigned PayloadIdxW  = 2;
    localparam int unsigned DriveW       = 7;
    localparam int unsigned AngleW       = 9;
    localparam int unsigned CmdW         = 2 * DriveW + 2 * AngleW + 1;
    localparam int unsigned OutTdataW    = ((CmdW + 7) / 8) * 8;
    localparam int unsigned AddrW        = 4;
    localparam int unsigned DataW        = 32;

    localparam logic [ByteW-1:0]  StartReset = 8'd224;
    localparam logic [ByteW-1:0]  StopReset  = 8'd192;
    localparam logic [LimitW-1:0] LimitReset = 4'd3;
    localparam logic [CountW-1:0] CountMax   = 5'd31;

    localparam logic signed [DriveW-1:0] DriveMax = 7'sd63;

    localparam logic signed [AngleW-1:0] ArmCodes [PayloadDepth] =
        '{-9'sd1, 9'sd43, 9'sd125, 9'sd170};
    localparam logic signed [AngleW-1:0] BoxCodes [PayloadDepth] =
        '{-9'sd1, 9'sd0, 9'sd35, 9'sd160};

    typedef enum logic [1:0] {
        REG_START = 2'd0,
        REG_STOP  = 2'd1,
        REG_LIMIT = 2'd2
    } t_reg_idx;

    // left_drive sits in the lowest bits
    typedef struct packed {
        logic                     csv_enable;
        logic signed [AngleW-1:0] box_target;
        logic signed [AngleW-1:0] arm_target;
        logic signed [DriveW-1:0] right_drive;
        logic signed [DriveW-1:0] left_drive;
    } t_cmd;

    typedef struct packed {
        logic close;
        t_cmd cmd;
    } t_frame_out;

    function automatic logic signed [DriveW-1:0] drive_of(input logic signed [2:0] net);
        logic signed [DriveW-1:0] d;
        if (net[2]) begin
            d = -DriveMax;
        end else if (net != 3'sd0) begin
            d = DriveMax;
        end else begin
            d = '0;
        end
        return d;
    endfunction

    function automatic t_cmd decode(
        input logic [ByteW-1:0] b0,
        input logic [ByteW-1:0] b1,
        input logic [ByteW-1:0] b2,
        input logic [ByteW-1:0] b3
    );
        t_cmd             c;
        logic signed [2:0] net_l;
        logic signed [2:0] net_r;
        // bit 3 up, bit 2 down, bit 1 left, bit 0 right
        net_l = $signed({2'b00, b0[3]}) - $signed({2'b00, b0[2]})
              - $signed({2'b00, b0[1]}) + $signed({2'b00, b0[0]});
        net_r = $signed({2'b00, b0[3]}) - $signed({2'b00, b0[2]})
              + $signed({2'b00, b0[1]}) - $signed({2'b00, b0[0]});
        c.left_drive  = drive_of(net_l);
        c.right_drive = drive_of(net_r);
        c.arm_target  = ArmCodes[b1[5:4]];
        c.box_target  = BoxCodes[b2[5:4]];
        c.csv_enable  = (b3 != '0);
        return c;
    endfunction

endpackage

@@ sv/tfpd_frame.sv @@
// frame state, payload store and command decode for one byte per step
// depends on tfpd_pkg
`timescale 1ns / 1ps

module tfpd_frame (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_step,
    input  logic [tfpd_pkg::ByteW-1:0]     i_byte,
    input  logic [tfpd_pkg::ByteW-1:0]     i_start_byte,
    input  logic [tfpd_pkg::ByteW-1:0]     i_stop_byte,
    input  logic [tfpd_pkg::LimitW-1:0]    i_length_limit,
    output tfpd_pkg::t_frame_out           o_frame
);
    import tfpd_pkg::*;

    logic                r_in_frame;
    logic                n_in_frame;
    logic [CountW-1:0]   r_count;
    logic [CountW-1:0]   n_count;
    logic [ByteW-1:0]    r_payload [PayloadDepth];
    logic                w_open;
    logic                w_close;
    logic                w_store;

    assign w_open  = !r_in_frame && (i_byte == i_start_byte);
    assign w_close = r_in_frame &&
                     ((i_byte == i_stop_byte) || (r_count > {1'b0, i_length_limit}));
    assign w_store = r_in_frame && !w_close &&
                     (r_count < CountW'(PayloadDepth));

    always_comb begin
        n_in_frame = r_in_frame;
        n_count    = r_count;
        if (i_step) begin
            if (w_open) begin
                n_in_frame = 1'b1;
                n_count    = '0;
            end else if (w_close) begin
                n_in_frame = 1'b0;
            end else if (r_in_frame && (r_count != CountMax)) begin
                n_count = r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_count    <= '0;
        end else begin
            r_in_frame <= n_in_frame;
            r_count    <= n_count;
        end
    end

    // payload store, cleared when a frame opens
    always_ff @(posedge i_clk) begin
        if (i_step && w_open) begin
            for (int i = 0; i < PayloadDepth; i++) begin
                r_payload[i] <= '0;
            end
        end else if (i_step && w_store) begin
            r_payload[r_count[PayloadIdxW-1:0]] <= i_byte;
        end
    end

    assign o_frame.close = i_step && w_close;
    assign o_frame.cmd   = decode(r_payload[0], r_payload[1], r_payload[2], r_payload[3]);

endmodule

@@ sv/teleop_frame_parser_decoder_core.sv @@
// top level of the teleop frame parser: stream ports, config registers, output register
// depends on tfpd_pkg and tfpd_frame
`timescale 1ns / 1ps

// Usage
//   Input stream: one received byte per word on i_s_axis_tdata[7:0].
//   Output stream: one decoded command per closed frame on o_m_axis_tdata.
//   A start byte outside a frame opens it; the stop byte, or the first byte
//   that arrives once more than length_limit payload bytes are received,
//   closes it and produces a command. Other bytes produce no word.
//   Config: APB registers start_byte at 0x0, stop_byte at 0x4,
//   length_limit at 0x8; write them only while no byte is in flight.
// Timing
//   A byte is held in the input register and decoded into the output
//   register once the output is free, so a command passes through both
//   registers. One byte per cycle is sustained while the receiver keeps up.
// Reset and stall
//   Synchronous active-low reset drops both valid flags, closes any frame
//   and restores the register defaults. While the receiver stalls the
//   output word holds and one more byte is buffered in the input register;
//   then o_s_axis_tready falls.

module teleop_frame_parser_decoder_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [tfpd_pkg::ByteW-1:0]         i_s_axis_tdata,  // [7:0] rx_byte
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // [6:0] left_drive, [13:7] right_drive, [22:14] arm_target,
    // [31:23] box_target, [32] csv_enable, [39:33] zero
    output logic [tfpd_pkg::OutTdataW-1:0]     o_m_axis_tdata,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tfpd_pkg::AddrW-1:0]         paddr,
    input  logic [tfpd_pkg::DataW-1:0]         pwdata,
    output logic [tfpd_pkg::DataW-1:0]         prdata,
    output logic                               pready
);
    import tfpd_pkg::*;

    logic               r_in_valid;
    logic [ByteW-1:0]   r_in_byte;
    logic               r_out_valid;
    t_cmd               r_out_cmd;
    logic [ByteW-1:0]   r_start_byte;
    logic [ByteW-1:0]   r_stop_byte;
    logic [LimitW-1:0]  r_length_limit;
    logic               w_advance;
    logic               w_cfg_write;
    t_frame_out         w_frame;

    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte   <= StartReset;
            r_stop_byte    <= StopReset;
            r_length_limit <= LimitReset;
        end else if (w_cfg_write) begin
            case (t_reg_idx'(paddr[3:2]))
                REG_START: r_start_byte   <= pwdata[ByteW-1:0];
                REG_STOP:  r_stop_byte    <= pwdata[ByteW-1:0];
                REG_LIMIT: r_length_limit <= pwdata[LimitW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (t_reg_idx'(paddr[3:2]))
            REG_START: prdata = DataW'(r_start_byte);
            REG_STOP:  prdata = DataW'(r_stop_byte);
            REG_LIMIT: prdata = DataW'(r_length_limit);
            default:   prdata = '0;
        endcase
    end

    assign w_advance       = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
        end
    end

    tfpd_frame u_frame (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (w_advance),
        .i_byte         (r_in_byte),
        .i_start_byte   (r_start_byte),
        .i_stop_byte    (r_stop_byte),
        .i_length_limit (r_length_limit),
        .o_frame        (w_frame)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_frame.close;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_frame.close) begin
            r_out_cmd <= w_frame.cmd;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(OutTdataW - CmdW)'(0), r_out_cmd};

endmodule

@@ sv/tfpd_checker.sv @@
// port-level checks on the output stream of the teleop frame parser, bound to the top level
// depends on tfpd_pkg and teleop_frame_parser_decoder_core
`timescale 1ns / 1ps

module tfpd_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_m_axis_tvalid,
    input logic                           i_m_axis_tready,
    input logic [tfpd_pkg::OutTdataW-1:0] o_m_axis_tdata
);
    import tfpd_pkg::*;

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("output word changed while stalled");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");

    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[6:0] != 7'h40) && (o_m_axis_tdata[13:7] != 7'h40)
            && (o_m_axis_tdata[OutTdataW-1:CmdW] == '0))
        else $error("drive out of range or pad bits set");

    a_arm_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[22:14] == 9'h1ff) || (o_m_axis_tdata[22:14] == 9'd43)
            || (o_m_axis_tdata[22:14] == 9'd125) || (o_m_axis_tdata[22:14] == 9'd170))
        else $error("arm target not a known angle");

endmodule

bind teleop_frame_parser_decoder_core tfpd_checker u_tfpd_checker (.*);

@@ tb/teleop_frame_parser_decoder_core_tb.sv @@
// self-checking testbench for teleop_frame_parser_decoder_core: byte stream in, decoded commands out
// predicts every command from its own frame tracker and compares field by field; needs tfpd_pkg
`timescale 1ns / 1ps

module teleop_frame_parser_decoder_core_tb;
    import tfpd_pkg::*;

    localparam int ClkPeriod   = 10;
    localparam int CycleLimit  = 200000;
    localparam int DrainCycles = 8;
    localparam int PowerStep   = 63;

    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [ByteW-1:0]     i_s_axis_tdata  = '0;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [OutTdataW-1:0] o_m_axis_tdata;
    logic                 psel            = 1'b0;
    logic                 penable         = 1'b0;
    logic                 pwrite          = 1'b0;
    logic [AddrW-1:0]     paddr           = '0;
    logic [DataW-1:0]     pwdata          = '0;
    logic [DataW-1:0]     prdata;
    logic                 pready;

    teleop_frame_parser_decoder_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #(ClkPeriod / 2) i_clk = ~i_clk;

    // frame tracker copy of the block
    logic [ByteW-1:0]  open_code    = StartReset;
    logic [ByteW-1:0]  close_code   = StopReset;
    logic [LimitW-1:0] max_len      = LimitReset;
    logic              in_cmd_frame = 1'b0;
    logic [CountW-1:0] stored_count = '0;
    logic [ByteW-1:0]  stored_bytes [PayloadDepth] = '{default: '0};

    t_cmd cmd_expected [$];
    t_cmd want_cmd;
    t_cmd seen_cmd;

    int bytes_used      = 0;
    int errors          = 0;
    int cycles          = 0;
    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    int hold_off_cycles = 0;

    function automatic logic signed [DriveW-1:0] clamp_power(input int v);
        if (v > PowerStep) begin
            return DriveMax;
        end else if (v < -PowerStep) begin
            return -DriveMax;
        end
        return DriveW'(v);
    endfunction

    function automatic t_cmd command_of_frame();
        t_cmd             c;
        int               l;
        int               r;
        logic [ByteW-1:0] d;
        d = stored_bytes[0];
        l = 0;
        r = 0;
        // up, down, left, right
        if (d[3]) begin
            l += PowerStep;
            r += PowerStep;
        end
        if (d[2]) begin
            l -= PowerStep;
            r -= PowerStep;
        end
        if (d[1]) begin
            l -= PowerStep;
            r += PowerStep;
        end
        if (d[0]) begin
            l += PowerStep;
            r -= PowerStep;
        end
        c.left_drive  = clamp_power(l);
        c.right_drive = clamp_power(r);
        case (stored_bytes[1][5:4])
            2'd0: c.arm_target = -9'sd1;
            2'd1: c.arm_target = 9'sd43;
            2'd2: c.arm_target = 9'sd125;
            default: c.arm_target = 9'sd170;
        endcase
        case (stored_bytes[2][5:4])
            2'd0: c.box_target = -9'sd1;
            2'd1: c.box_target = 9'sd0;
            2'd2: c.box_target = 9'sd35;
            default: c.box_target = 9'sd160;
        endcase
        c.csv_enable = (stored_bytes[3] != '0);
        return c;
    endfunction

    task automatic track_byte(input logic [ByteW-1:0] b);
        if (!in_cmd_frame) begin
            if (b == open_code) begin
                in_cmd_frame = 1'b1;
                stored_count = '0;
                foreach (stored_bytes[i]) stored_bytes[i] = '0;
                bytes_used++;
            end
        end else begin
            bytes_used++;
            if (b == close_code || stored_count > max_len) begin
                cmd_expected.push_back(command_of_frame());
                in_cmd_frame = 1'b0;
            end else begin
                if (stored_count < PayloadDepth) stored_bytes[stored_count[PayloadIdxW-1:0]] = b;
                if (stored_count < CountMax) stored_count++;
            end
        end
    endtask

    task automatic flag_error(input string what, input int want, input int seen);
        errors++;
        if (errors <= 10) begin
            $display("t=%0t %s: expected %0d, got %0d", $time, what, want, seen);
        end
    endtask

    // receiver: random stalls plus an optional long hold-off
    always @(posedge i_clk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            seen_cmd = t_cmd'(o_m_axis_tdata[CmdW-1:0]);
            if (cmd_expected.size() == 0) begin
                flag_error("command word with none pending", 0, 1);
            end else begin
                want_cmd = cmd_expected.pop_front();
                if (seen_cmd.left_drive !== want_cmd.left_drive)
                    flag_error("left_drive", int'(want_cmd.left_drive),
                               int'(seen_cmd.left_drive));
                if (seen_cmd.right_drive !== want_cmd.right_drive)
                    flag_error("right_drive", int'(want_cmd.right_drive),
                               int'(seen_cmd.right_drive));
                if (seen_cmd.arm_target !== want_cmd.arm_target)
                    flag_error("arm_target", int'(want_cmd.arm_target),
                               int'(seen_cmd.arm_target));
                if (seen_cmd.box_target !== want_cmd.box_target)
                    flag_error("box_target", int'(want_cmd.box_target),
                               int'(seen_cmd.box_target));
                if (seen_cmd.csv_enable !== want_cmd.csv_enable)
                    flag_error("csv_enable", int'(want_cmd.csv_enable),
                               int'(seen_cmd.csv_enable));
            end
            if (o_m_axis_tdata[OutTdataW-1:CmdW] !== '0)
                flag_error("tdata pad bits", 0, int'(o_m_axis_tdata[OutTdataW-1:CmdW]));
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CycleLimit) begin
            $display("teleop_frame_parser_decoder_core_tb: FAIL");
            $finish;
        end
    end

    task automatic send_byte(input logic [ByteW-1:0] b);
        if ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        do @(posedge i_clk); while (!o_s_axis_tready);
        track_byte(b);
    endtask

    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        while (cmd_expected.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [DataW-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_START: open_code  = v[ByteW-1:0];
            REG_STOP:  close_code = v[ByteW-1:0];
            REG_LIMIT: max_len    = v[LimitW-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_regs(input logic [ByteW-1:0] s, input logic [ByteW-1:0] p,
                            input logic [LimitW-1:0] l);
        wait_idle();
        write_reg(REG_START, DataW'(s));
        write_reg(REG_STOP, DataW'(p));
        write_reg(REG_LIMIT, DataW'(l));
    endtask

    task automatic test_directed_frames();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // stop byte and zero byte outside a frame are ignored
        send_byte(StopReset);
        send_byte(8'h00);
        // empty frame, all payload reads as zero
        send_byte(StartReset);
        send_byte(StopReset);
        // all direction bits, top arm selector, closed by length
        send_byte(StartReset);
        send_byte(8'h0F);
        send_byte(8'h30);
        send_byte(8'h10);
        send_byte(8'hFF);
        send_byte(8'h55);
        // start byte inside a frame is payload
        send_byte(StartReset);
        send_byte(StartReset);
        send_byte(8'h29);
        send_byte(StopReset);
        // up and right saturate
        send_byte(StartReset);
        send_byte(8'h09);
        send_byte(8'h10);
        send_byte(8'h20);
        send_byte(StopReset);
        // down and left saturate
        send_byte(StartReset);
        send_byte(8'h06);
        send_byte(StopReset);
    endtask

    task automatic test_count_bound();
        set_regs(StartReset, StopReset, 4'd15);
        send_byte(open_code);
        repeat (16) send_byte(8'h3A);
        send_byte(8'h7E);
    endtask

    task automatic test_backpressure();
        set_regs(StartReset, StopReset, LimitReset);
        hold_off_cycles = 300;
        repeat (8) begin
            send_byte(open_code);
            repeat (3) send_byte(8'($urandom_range(8'hBF)));
            send_byte(close_code);
        end
    endtask

    task automatic test_random_traffic(input logic [ByteW-1:0] s, input logic [ByteW-1:0] p,
                                       input logic [LimitW-1:0] l, input int snd_idle,
                                       input int rcv_stall, input int n);
        int goal;
        int k;
        set_regs(s, p, l);
        send_idle_pct  = snd_idle;
        recv_stall_pct = rcv_stall;
        goal = bytes_used + n;
        while (bytes_used < goal) begin
            if ($urandom_range(99) < 15) begin
                send_byte(8'($urandom));
            end else begin
                send_byte(open_code);
                k = $urandom_range(int'(max_len) + 2);
                repeat (k) send_byte(8'($urandom));
                if ($urandom_range(99) < 80) send_byte(close_code);
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_frames();
        test_count_bound();
        test_backpressure();
        test_random_traffic(StartReset, StopReset, LimitReset, 0, 0, 250);
        test_random_traffic(8'h00, 8'hFF, 4'd0, 52, 0, 250);
        test_random_traffic(8'hFF, 8'h00, 4'd15, 0, 52, 250);
        test_random_traffic(8'($urandom), 8'($urandom), 4'($urandom), 36, 36, 250);
        i_s_axis_tvalid <= 1'b0;
        while (cmd_expected.size() != 0) @(posedge i_clk);
        repeat (2 * DrainCycles) @(posedge i_clk);
        if (errors == 0 && cmd_expected.size() == 0) begin
            $display("teleop_frame_parser_decoder_core_tb: PASS");
        end else begin
            $display("teleop_frame_parser_decoder_core_tb: FAIL");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
sv/tfpd_pkg.sv
sv/tfpd_frame.sv
sv/teleop_frame_parser_decoder_core.sv
sv/tfpd_checker.sv
tb/teleop_frame_parser_decoder_core_tb.sv
